### rtl/tlnd_pkg.sv
// Shared constants, codes and controller/datapath interface types of the name directory.
`default_nettype none
package tlnd_pkg;

  localparam int MAX_DIRS      = 16;
  localparam int FILES_PER_DIR = 16;
  localparam int NAME_BYTES    = 8;

  localparam int KEY_W    = 64;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int TOTAL_W  = 5;

  localparam int DIR_IDX_W  = $clog2(MAX_DIRS);
  localparam int FILE_IDX_W = $clog2(FILES_PER_DIR);
  localparam int DIR_CNT_W  = $clog2(MAX_DIRS + 1);
  localparam int FILE_CNT_W = $clog2(FILES_PER_DIR + 1);
  localparam int SCAN_W     = (DIR_CNT_W > FILE_CNT_W) ? DIR_CNT_W : FILE_CNT_W;
  localparam int FADDR_W    = DIR_IDX_W + FILE_IDX_W;
  localparam int FMEM_DEPTH = MAX_DIRS << FILE_IDX_W;

  localparam int IN_DATA_W  = ((FUNC_W + 2 * KEY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((STATUS_W + 2 * SLOT_W + TOTAL_W + 7) / 8) * 8;

  // Only the low NAME_BYTES bytes of a key take part in storage and compare.
  localparam logic [KEY_W-1:0] NAME_MASK =
    (NAME_BYTES >= 8) ? {KEY_W{1'b1}} : ((KEY_W'(1) << (8 * NAME_BYTES)) - KEY_W'(1));

  typedef enum logic [FUNC_W-1:0] {
    FN_MK_DIR  = 2'd0,
    FN_MK_FILE = 2'd1,
    FN_DEL     = 2'd2,
    FN_SEARCH  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_DIR    = 3'd1,
    ST_NO_FILE   = 3'd2,
    ST_DIR_FULL  = 3'd3,
    ST_FILE_FULL = 3'd4
  } status_t;

  typedef struct packed {
    logic    latch_req;
    logic    dir_create;
    logic    file_create;
    logic    scan_start;
    logic    scan_file;
    logic    move_rd;
    logic    move_wr;
    logic    resp_load;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  dir_full;
    logic  dir_none;
    logic  file_full;
    logic  file_none;
    logic  hit;
    logic  miss;
    logic  out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/two_level_name_directory_core.sv
// Top level of the two-level name directory: stream ports, sequencer and datapath.
//
//  Channel  Direction  Payload
//  in_      slave      tdata = func[1:0], dir_key[65:2], file_key[129:66], zero pad to 136
//  out_     master     tdata = status[2:0], dir_slot[6:3], file_slot[10:7], file_total[15:11]
//
// One request at a time. Create directory needs no scan; other requests scan the
// directory table and, for search and delete, then the file list at one entry per cycle
// through registered memory reads. After a hit, delete moves the last file into the freed slot.
// Reset (rst_n low, synchronous) empties the directory table; name memories are not cleared.
// A finished result waits in an output register while the next request is taken.
`default_nettype none
module two_level_name_directory_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [tlnd_pkg::IN_DATA_W-1:0]       in_tdata,   // func, dir_key, file_key
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [tlnd_pkg::OUT_DATA_W-1:0]      out_tdata   // status, dir_slot, file_slot, file_total
);

  localparam int KW = tlnd_pkg::KEY_W;
  localparam int FN = tlnd_pkg::FUNC_W;

  tlnd_pkg::dp_cmd_t  cmd;
  tlnd_pkg::dp_stat_t stat;

  logic [tlnd_pkg::STATUS_W-1:0] res_status;
  logic [tlnd_pkg::SLOT_W-1:0]   res_dir_slot, res_file_slot;
  logic [tlnd_pkg::TOTAL_W-1:0]  res_file_total;

  tlnd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlnd_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_func       (in_tdata[FN-1:0]),
    .req_dir_key    (in_tdata[FN+KW-1:FN]),
    .req_file_key   (in_tdata[FN+2*KW-1:FN+KW]),
    .cmd            (cmd),
    .stat           (stat),
    .res_valid      (out_tvalid),
    .res_ready      (out_tready),
    .res_status     (res_status),
    .res_dir_slot   (res_dir_slot),
    .res_file_slot  (res_file_slot),
    .res_file_total (res_file_total)
  );

  assign out_tdata = tlnd_pkg::OUT_DATA_W'({res_file_total, res_file_slot, res_dir_slot,
                                            res_status});

endmodule
`default_nettype wire

### rtl/tlnd_ctrl.sv
// Request sequencer of the name directory: one-hot state machine issuing datapath commands.
`default_nettype none
module tlnd_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                req_valid,
  output logic               req_ready,
  input  tlnd_pkg::dp_stat_t stat,
  output tlnd_pkg::dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_START  = 8'b0000_0010,
    S_DSCAN  = 8'b0000_0100,
    S_DFOUND = 8'b0000_1000,
    S_FSCAN  = 8'b0001_0000,
    S_MOVERD = 8'b0010_0000,
    S_MOVEWR = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  tlnd_pkg::status_t status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= tlnd_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  assign req_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    case (state_r)
      S_IDLE: begin
        cmd.latch_req = req_valid;
        if (req_valid) state_nxt = S_START;
      end
      S_START: begin
        state_nxt = S_RESP;
        if (stat.func == tlnd_pkg::FN_MK_DIR) begin
          if (stat.dir_full) begin
            status_nxt = tlnd_pkg::ST_DIR_FULL;
          end else begin
            cmd.dir_create = 1'b1;
            status_nxt     = tlnd_pkg::ST_OK;
          end
        end else if (stat.dir_none) begin
          status_nxt = tlnd_pkg::ST_NO_DIR;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_DSCAN;
        end
      end
      S_DSCAN: begin
        if (stat.hit) begin
          state_nxt = S_DFOUND;
        end else if (stat.miss) begin
          status_nxt = tlnd_pkg::ST_NO_DIR;
          state_nxt  = S_RESP;
        end
      end
      S_DFOUND: begin
        state_nxt = S_RESP;
        if (stat.func == tlnd_pkg::FN_MK_FILE) begin
          if (stat.file_full) begin
            status_nxt = tlnd_pkg::ST_FILE_FULL;
          end else begin
            cmd.file_create = 1'b1;
            status_nxt      = tlnd_pkg::ST_OK;
          end
        end else if (stat.file_none) begin
          status_nxt = tlnd_pkg::ST_NO_FILE;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_file  = 1'b1;
          state_nxt      = S_FSCAN;
        end
      end
      S_FSCAN: begin
        if (stat.hit) begin
          status_nxt = tlnd_pkg::ST_OK;
          state_nxt  = (stat.func == tlnd_pkg::FN_DEL) ? S_MOVERD : S_RESP;
        end else if (stat.miss) begin
          status_nxt = tlnd_pkg::ST_NO_FILE;
          state_nxt  = S_RESP;
        end
      end
      S_MOVERD: begin
        cmd.move_rd = 1'b1;
        state_nxt   = S_MOVEWR;
      end
      S_MOVEWR: begin
        cmd.move_wr = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/tlnd_dpath.sv
// Datapath of the name directory: name memories, counts, scan unit and result register.
`default_nettype none
module tlnd_dpath (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire  [tlnd_pkg::FUNC_W-1:0]            req_func,
  input  wire  [tlnd_pkg::KEY_W-1:0]             req_dir_key,
  input  wire  [tlnd_pkg::KEY_W-1:0]             req_file_key,
  input  tlnd_pkg::dp_cmd_t                      cmd,
  output tlnd_pkg::dp_stat_t                     stat,
  output logic                                   res_valid,
  input  wire                                    res_ready,
  output logic [tlnd_pkg::STATUS_W-1:0]          res_status,
  output logic [tlnd_pkg::SLOT_W-1:0]            res_dir_slot,
  output logic [tlnd_pkg::SLOT_W-1:0]            res_file_slot,
  output logic [tlnd_pkg::TOTAL_W-1:0]           res_file_total
);

  localparam int DW  = tlnd_pkg::DIR_IDX_W;
  localparam int FW  = tlnd_pkg::FILE_IDX_W;
  localparam int SW  = tlnd_pkg::SCAN_W;
  localparam int KW  = tlnd_pkg::KEY_W;
  localparam int FCW = tlnd_pkg::FILE_CNT_W;

  // Request registers.
  tlnd_pkg::func_t func_r;
  logic [KW-1:0]   dkey_r, fkey_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      func_r <= tlnd_pkg::func_t'(req_func);
      dkey_r <= req_dir_key & tlnd_pkg::NAME_MASK;
      fkey_r <= req_file_key & tlnd_pkg::NAME_MASK;
    end
  end

  // Directory count and per-directory file counts.
  logic [tlnd_pkg::DIR_CNT_W-1:0] dir_total_r;
  logic [FCW-1:0]                 cnt_r [tlnd_pkg::MAX_DIRS];
  logic [DW-1:0]                  d_r;
  logic [FW-1:0]                  k_r;
  logic [FCW-1:0]                 cur_cnt;
  logic [FCW-1:0]                 last_cnt;

  assign cur_cnt  = cnt_r[d_r];
  assign last_cnt = cur_cnt - FCW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_total_r <= '0;
    end else if (cmd.dir_create) begin
      dir_total_r <= dir_total_r + tlnd_pkg::DIR_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dir_create) begin
      cnt_r[dir_total_r[DW-1:0]] <= '0;
    end else if (cmd.file_create) begin
      cnt_r[d_r] <= cur_cnt + FCW'(1);
    end else if (cmd.move_wr) begin
      cnt_r[d_r] <= last_cnt;
    end
  end

  // Scan unit: one read issued per cycle, compared in the cycle after it is issued.
  logic          scan_active_r, scan_file_r, cmp_vld_r;
  logic [SW-1:0] issue_r, cmp_idx_r, limit;
  logic          issue_en, match, hit, miss;
  logic [KW-1:0] dir_rd_r, file_rd_r;

  assign limit    = scan_file_r ? SW'(cur_cnt) : SW'(dir_total_r);
  assign issue_en = scan_active_r && (issue_r < limit);
  assign match    = scan_file_r ? (file_rd_r == fkey_r) : (dir_rd_r == dkey_r);
  assign hit      = scan_active_r && cmp_vld_r && match;
  assign miss     = scan_active_r && cmp_vld_r && !match &&
                    ((cmp_idx_r + SW'(1)) == limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_active_r <= 1'b0;
      cmp_vld_r     <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_active_r <= 1'b1;
      cmp_vld_r     <= 1'b0;
    end else if (hit || miss) begin
      scan_active_r <= 1'b0;
      cmp_vld_r     <= 1'b0;
    end else if (scan_active_r) begin
      cmp_vld_r <= issue_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      issue_r     <= '0;
      scan_file_r <= cmd.scan_file;
    end else if (issue_en) begin
      issue_r <= issue_r + SW'(1);
    end
    cmp_idx_r <= issue_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.dir_create) begin
      d_r <= dir_total_r[DW-1:0];
    end else if (hit && !scan_file_r) begin
      d_r <= cmp_idx_r[DW-1:0];
    end
    if (cmd.file_create) begin
      k_r <= cur_cnt[FW-1:0];
    end else if (hit && scan_file_r) begin
      k_r <= cmp_idx_r[FW-1:0];
    end
  end

  // Directory name memory.
  logic [KW-1:0] dir_mem [tlnd_pkg::MAX_DIRS];

  always_ff @(posedge clk) begin
    if (cmd.dir_create) begin
      dir_mem[dir_total_r[DW-1:0]] <= dkey_r;
    end
    dir_rd_r <= dir_mem[issue_r[DW-1:0]];
  end

  // File name memory, addressed by directory slot and file slot.
  logic [KW-1:0]                  file_mem [tlnd_pkg::FMEM_DEPTH];
  logic [tlnd_pkg::FADDR_W-1:0]   f_rd_addr, f_wr_addr;
  logic [KW-1:0]                  f_wr_data;
  logic                           f_wr_en;

  assign f_rd_addr = cmd.move_rd ? {d_r, last_cnt[FW-1:0]} : {d_r, issue_r[FW-1:0]};
  assign f_wr_en   = cmd.file_create || cmd.move_wr;
  assign f_wr_addr = cmd.move_wr ? {d_r, k_r} : {d_r, cur_cnt[FW-1:0]};
  assign f_wr_data = cmd.move_wr ? file_rd_r : fkey_r;

  always_ff @(posedge clk) begin
    if (f_wr_en) begin
      file_mem[f_wr_addr] <= f_wr_data;
    end
    file_rd_r <= file_mem[f_rd_addr];
  end

  // Result register; a new request may be taken while it waits.
  logic                          dir_known, file_known;
  logic                          res_valid_r;
  logic [tlnd_pkg::STATUS_W-1:0] res_status_r;
  logic [tlnd_pkg::SLOT_W-1:0]   res_dir_slot_r, res_file_slot_r;
  logic [tlnd_pkg::TOTAL_W-1:0]  res_file_total_r;

  assign dir_known  = (cmd.status != tlnd_pkg::ST_NO_DIR) &&
                      (cmd.status != tlnd_pkg::ST_DIR_FULL);
  assign file_known = (cmd.status == tlnd_pkg::ST_OK) && (func_r != tlnd_pkg::FN_MK_DIR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (cmd.resp_load) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      res_status_r     <= cmd.status;
      res_dir_slot_r   <= dir_known ? tlnd_pkg::SLOT_W'(d_r) : '0;
      res_file_slot_r  <= file_known ? tlnd_pkg::SLOT_W'(k_r) : '0;
      res_file_total_r <= dir_known ? tlnd_pkg::TOTAL_W'(cur_cnt) : '0;
    end
  end

  assign res_valid      = res_valid_r;
  assign res_status     = res_status_r;
  assign res_dir_slot   = res_dir_slot_r;
  assign res_file_slot  = res_file_slot_r;
  assign res_file_total = res_file_total_r;

  assign stat.func      = func_r;
  assign stat.dir_full  = (dir_total_r >= tlnd_pkg::DIR_CNT_W'(tlnd_pkg::MAX_DIRS));
  assign stat.dir_none  = (dir_total_r == '0);
  assign stat.file_full = (cur_cnt >= FCW'(tlnd_pkg::FILES_PER_DIR));
  assign stat.file_none = (cur_cnt == '0);
  assign stat.hit       = hit;
  assign stat.miss      = miss;
  assign stat.out_free  = !res_valid_r || res_ready;

  a_hit_miss_excl: assert property (@(posedge clk) disable iff (!rst_n) !(hit && miss))
    else $error("scan reported hit and miss together");
  a_dir_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.dir_create |=> $stable(dir_total_r))
    else $error("directory count changed without a create");
  a_dir_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dir_total_r <= tlnd_pkg::DIR_CNT_W'(tlnd_pkg::MAX_DIRS))
    else $error("directory count beyond table size");
  a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move_wr |-> (cur_cnt != '0))
    else $error("delete on an empty file list");

endmodule
`default_nettype wire
